### hw/rtl/mmo_pkg.sv
`timescale 1ns / 1ps
package mmo_pkg;

   localparam int SAMPLE_W = 18;
   localparam int DATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int LIMIT_W = 17;
   localparam int BAND_W = 8;
   localparam int FRACTION_BITS = 4;
   localparam int DEFAULT_WINDOW_LENGTH = 8;

   localparam int LIMIT_MAX = (1 << LIMIT_W) - 1;
   localparam int BAND_MAX = (1 << BAND_W) - 1;
   localparam int CLAMP_SCALED = 2500 << FRACTION_BITS;
   localparam int THRESHOLD_SCALED = 100 << FRACTION_BITS;
   localparam int LARGE_SCALED = 5000 << FRACTION_BITS;
   localparam int BAND_SCALED = 1 << FRACTION_BITS;

   localparam logic [LIMIT_W-1:0] CLAMP_RESET =
      LIMIT_W'((CLAMP_SCALED > LIMIT_MAX) ? LIMIT_MAX : CLAMP_SCALED);
   localparam logic [LIMIT_W-1:0] THRESHOLD_RESET =
      LIMIT_W'((THRESHOLD_SCALED > LIMIT_MAX) ? LIMIT_MAX : THRESHOLD_SCALED);
   localparam logic [LIMIT_W-1:0] LARGE_RESET =
      LIMIT_W'((LARGE_SCALED > LIMIT_MAX) ? LIMIT_MAX : LARGE_SCALED);
   localparam logic [BAND_W-1:0] BAND_RESET =
      BAND_W'((BAND_SCALED > BAND_MAX) ? BAND_MAX : BAND_SCALED);

   // register indexes
   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_CLAMP = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_LARGE = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_BAND = 2'd3;

   // shared unit operations
   localparam int ALU_OP_W = 3;
   localparam logic [ALU_OP_W-1:0] ALU_RANK = 3'd0;
   localparam logic [ALU_OP_W-1:0] ALU_ACC = 3'd1;
   localparam logic [ALU_OP_W-1:0] ALU_DEV = 3'd2;
   localparam logic [ALU_OP_W-1:0] ALU_ABS = 3'd3;
   localparam logic [ALU_OP_W-1:0] ALU_NEG = 3'd5;

   typedef struct packed {
      logic push;
      logic rotate;
      logic overwrite;
   } win_ctl_type;

endpackage

### hw/rtl/median_mean_outlier_speed_filter.sv
`timescale 1ns / 1ps
// Two-stage speed filter: each request is clamped to +/- clamp_limit, passes a
// windowed median/mean stage and then a median outlier stage, and gives one
// response. One request is in work at a time; req_tready is high only while
// idle, and a finished response waits in the output register. The rank
// compares, the window sum and the deviation share the single add/compare unit:
// the median rank search compares every window entry against every other one
// cycle at a time, and the window sum is built one entry a cycle; the mean then
// takes one constant reciprocal multiply.
module median_mean_outlier_speed_filter #(
   parameter int WINDOW_LENGTH = mmo_pkg::DEFAULT_WINDOW_LENGTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mmo_pkg::DATA_W-1:0]        req_tdata,  // raw_speed
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mmo_pkg::DATA_W-1:0]        rsp_tdata,  // filtered_speed
   output logic [1:0]                        rsp_tuser,  // outlier_fixed, startup_seen
   input  logic                              csr_wen,
   input  logic [mmo_pkg::REG_IDX_W-1:0]     csr_index,
   input  logic [mmo_pkg::LIMIT_W-1:0]       csr_wdata
);
   import mmo_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_LENGTH);
   localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
   localparam int ACC_W = SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int AW = ACC_W + 1;
   localparam int MED_RANK = WINDOW_LENGTH / 2;
   localparam int STARTUP_MIN = WINDOW_LENGTH - 2;
   localparam int RECIP_SHIFT = ACC_W + $clog2(WINDOW_LENGTH);
   localparam int PROD_W = RECIP_SHIFT + ACC_W;
   localparam longint RECIP_FULL = ((longint'(1) << RECIP_SHIFT) +
      longint'(WINDOW_LENGTH) - longint'(1)) / longint'(WINDOW_LENGTH);
   localparam logic [AW-1:0] RECIP = AW'(RECIP_FULL);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PUSH  = 4'd1;
   localparam logic [3:0] S_CAND  = 4'd2;
   localparam logic [3:0] S_SCAN  = 4'd3;
   localparam logic [3:0] S_NEXT  = 4'd4;
   localparam logic [3:0] S_JUDGE = 4'd5;
   localparam logic [3:0] S_SUM   = 4'd6;
   localparam logic [3:0] S_ABS   = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_SIGN  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [LIMIT_W-1:0] clamp_ff, thr_ff, large_ff;
   logic [BAND_W-1:0] band_ff;

   logic [3:0] state_ff, state_in;
   logic stage_ff, stage_in;
   logic signed [SAMPLE_W-1:0] in_ff, in_in, cand_ff, cand_in, med_ff, med_in;
   logic [CNT_W-1:0] lt_ff, lt_in, le_ff, le_in, zero_ff, zero_in;
   logic [IDX_W-1:0] pass_ff, pass_in, step_ff, step_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] quo_ff, quo_in;
   logic neg_ff, neg_in, start_ff, start_in, fixed_ff, fixed_in;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_start_ff, rsp_start_in, rsp_fixed_ff, rsp_fixed_in;
   logic [PROD_W-1:0] mean_prod;

   win_ctl_type ctl1, ctl2;
   logic do_push, do_rot, do_ovr;
   logic signed [SAMPLE_W-1:0] ovr_val, win1_din, tap1, tap2, tap;
   logic w1_fill_hi, w2_fill_hi, fill_hi;

   logic [ALU_OP_W-1:0] alu_op;
   logic signed [AW-1:0] alu_sum;
   logic alu_neg, alu_zero;

   logic signed [SAMPLE_W:0] raw_wide, lim_wide, lim_neg, tap_wide, band_wide, band_neg;
   logic signed [SAMPLE_W:0] samp_wide, large_wide;
   logic signed [SAMPLE_W-1:0] clamped;
   logic signed [AW-1:0] thr_wide, thr_neg;
   logic near_zero, large_hi, dev_hi, startup;

   // clamp of the incoming request
   always_comb begin
      raw_wide = $signed({req_tdata[SAMPLE_W-1], req_tdata[SAMPLE_W-1:0]});
      lim_wide = $signed({{(SAMPLE_W + 1 - LIMIT_W){1'b0}}, clamp_ff});
      lim_neg = -lim_wide;
      if (raw_wide > lim_wide) begin
         clamped = lim_wide[SAMPLE_W-1:0];
      end else if (raw_wide < lim_neg) begin
         clamped = lim_neg[SAMPLE_W-1:0];
      end else begin
         clamped = raw_wide[SAMPLE_W-1:0];
      end
   end

   assign tap = stage_ff ? tap2 : tap1;
   assign fill_hi = stage_ff ? w2_fill_hi : w1_fill_hi;

   assign tap_wide = $signed({tap[SAMPLE_W-1], tap});
   assign band_wide = $signed({{(SAMPLE_W + 1 - BAND_W){1'b0}}, band_ff});
   assign band_neg = -band_wide;
   assign near_zero = (tap_wide < band_wide) && (tap_wide > band_neg);

   assign samp_wide = $signed({in_ff[SAMPLE_W-1], in_ff});
   assign large_wide = $signed({{(SAMPLE_W + 1 - LIMIT_W){1'b0}}, large_ff});
   assign large_hi = samp_wide > large_wide;

   assign thr_wide = $signed({{(AW - LIMIT_W){1'b0}}, thr_ff});
   assign thr_neg = -thr_wide;
   assign dev_hi = (alu_sum > thr_wide) || (alu_sum < thr_neg);

   assign alu_neg = alu_sum[AW-1];
   assign alu_zero = (alu_sum == '0);
   assign startup = (zero_ff > CNT_W'(STARTUP_MIN));

   // mean magnitude by constant reciprocal
   assign mean_prod = PROD_W'(quo_ff) * PROD_W'(RECIP);

   mmo_alu #(
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) u_alu (
      .op    (alu_op),
      .tap   (tap),
      .cand  (cand_ff),
      .samp  (in_ff),
      .med   (med_ff),
      .acc   (acc_ff),
      .quo   (quo_ff),
      .result(alu_sum)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      in_in = in_ff;
      cand_in = cand_ff;
      med_in = med_ff;
      lt_in = lt_ff;
      le_in = le_ff;
      zero_in = zero_ff;
      pass_in = pass_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      start_in = start_ff;
      fixed_in = fixed_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_start_in = rsp_start_ff;
      rsp_fixed_in = rsp_fixed_ff;
      do_push = 1'b0;
      do_rot = 1'b0;
      do_ovr = 1'b0;
      ovr_val = '0;
      alu_op = ALU_RANK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               in_in = clamped;
               stage_in = 1'b0;
               start_in = 1'b0;
               fixed_in = 1'b0;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            do_push = 1'b1;
            pass_in = '0;
            if (fill_hi) begin
               state_in = S_CAND;
            end else if (stage_ff) begin
               state_in = S_OUT;
            end else begin
               stage_in = 1'b1;
            end
         end
         S_CAND: begin
            cand_in = tap;
            lt_in = '0;
            le_in = '0;
            step_in = '0;
            if (pass_ff == '0) begin
               zero_in = '0;
            end
            state_in = S_SCAN;
         end
         S_SCAN: begin
            alu_op = ALU_RANK;
            do_rot = 1'b1;
            lt_in = lt_ff + CNT_W'(alu_neg);
            le_in = le_ff + CNT_W'(alu_neg || alu_zero);
            if (pass_ff == '0) begin
               zero_in = zero_ff + CNT_W'(near_zero);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == IDX_W'(WINDOW_LENGTH - 1)) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (lt_ff <= CNT_W'(MED_RANK) && le_ff > CNT_W'(MED_RANK)) begin
               med_in = cand_ff;
            end
            do_rot = 1'b1;
            pass_in = pass_ff + 1'b1;
            if (pass_ff == IDX_W'(WINDOW_LENGTH - 1)) begin
               state_in = S_JUDGE;
            end else begin
               state_in = S_CAND;
            end
         end
         S_JUDGE: begin
            alu_op = ALU_DEV;
            if (!stage_ff) begin
               start_in = startup;
               if (!startup && large_hi) begin
                  do_ovr = 1'b1;
                  fixed_in = 1'b1;
               end else if (!startup && dev_hi) begin
                  do_ovr = 1'b1;
                  ovr_val = med_ff;
                  fixed_in = 1'b1;
               end
               acc_in = '0;
               step_in = '0;
               state_in = S_SUM;
            end else begin
               if (!startup && dev_hi) begin
                  in_in = med_ff;
                  fixed_in = 1'b1;
               end
               state_in = S_OUT;
            end
         end
         S_SUM: begin
            alu_op = ALU_ACC;
            do_rot = 1'b1;
            acc_in = alu_sum[ACC_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == IDX_W'(WINDOW_LENGTH - 1)) begin
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            alu_op = ALU_ABS;
            neg_in = acc_ff[ACC_W-1];
            quo_in = acc_ff[ACC_W-1] ? alu_sum[ACC_W-1:0] : acc_ff[ACC_W-1:0];
            state_in = S_DIV;
         end
         S_DIV: begin
            quo_in = mean_prod[RECIP_SHIFT +: ACC_W];
            state_in = S_SIGN;
         end
         S_SIGN: begin
            alu_op = ALU_NEG;
            in_in = neg_ff ? alu_sum[SAMPLE_W-1:0] : quo_ff[SAMPLE_W-1:0];
            stage_in = 1'b1;
            state_in = S_PUSH;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in = in_ff;
               rsp_start_in = start_ff;
               rsp_fixed_in = fixed_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl1.push = do_push && !stage_ff;
      ctl1.rotate = do_rot && !stage_ff;
      ctl1.overwrite = do_ovr;
      ctl2.push = do_push && stage_ff;
      ctl2.rotate = do_rot && stage_ff;
      ctl2.overwrite = 1'b0;
   end

   assign win1_din = do_push ? in_ff : ovr_val;

   mmo_window #(
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) u_first (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl1),
      .din    (win1_din),
      .tap0   (tap1),
      .fill_hi(w1_fill_hi)
   );

   mmo_window #(
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) u_second (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl2),
      .din    (in_ff),
      .tap0   (tap2),
      .fill_hi(w2_fill_hi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= CLAMP_RESET;
         thr_ff <= THRESHOLD_RESET;
         large_ff <= LARGE_RESET;
         band_ff <= BAND_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_CLAMP: clamp_ff <= csr_wdata;
            REG_THRESHOLD: thr_ff <= csr_wdata;
            REG_LARGE: large_ff <= csr_wdata;
            REG_BAND: band_ff <= csr_wdata[BAND_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      in_ff <= in_in;
      cand_ff <= cand_in;
      med_ff <= med_in;
      lt_ff <= lt_in;
      le_ff <= le_in;
      zero_ff <= zero_in;
      pass_ff <= pass_in;
      step_ff <= step_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      start_ff <= start_in;
      fixed_ff <= fixed_in;
      rsp_data_ff <= rsp_data_in;
      rsp_start_ff <= rsp_start_in;
      rsp_fixed_ff <= rsp_fixed_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {{(DATA_W - SAMPLE_W){1'b0}}, rsp_data_ff};
   assign rsp_tuser = {rsp_fixed_ff, rsp_start_ff};

   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT) |-> (lt_ff <= le_ff))
      else $error("rank counts out of order");

   a_mean_stage_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM || state_ff == S_ABS || state_ff == S_DIV ||
       state_ff == S_SIGN) |-> !stage_ff)
      else $error("mean pass in second stage");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == S_OUT))
      else $error("response overwritten while stalled");

   a_startup_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && start_ff) |-> w1_fill_hi)
      else $error("start-up flagged with first window not full");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_tvalid) |=> (state_ff == S_PUSH && !stage_ff))
      else $error("request not started in first stage");

endmodule

### hw/rtl/mmo_window.sv
`timescale 1ns / 1ps
module mmo_window #(
   parameter int WINDOW_LENGTH = mmo_pkg::DEFAULT_WINDOW_LENGTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mmo_pkg::win_ctl_type                 ctl,
   input  logic signed [mmo_pkg::SAMPLE_W-1:0]  din,
   output logic signed [mmo_pkg::SAMPLE_W-1:0]  tap0,
   output logic                                 fill_hi
);
   import mmo_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);

   logic signed [SAMPLE_W-1:0] taps_ff [WINDOW_LENGTH];
   logic signed [SAMPLE_W-1:0] taps_in [WINDOW_LENGTH];
   logic [FILL_W-1:0] fill_ff, fill_in;

   // oldest entry at tap zero, newest at the top; rotation walks the ring
   always_comb begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
         taps_in[i] = taps_ff[i];
      end
      if (ctl.push || ctl.rotate) begin
         for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
            taps_in[i] = taps_ff[i+1];
         end
         taps_in[WINDOW_LENGTH-1] = ctl.push ? din : taps_ff[0];
      end else if (ctl.overwrite) begin
         taps_in[WINDOW_LENGTH-1] = din;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctl.push && fill_ff != FILL_W'(WINDOW_LENGTH)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   assign tap0 = taps_ff[0];
   assign fill_hi = (fill_ff >= FILL_W'(WINDOW_LENGTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
         taps_ff[i] <= taps_in[i];
      end
   end

endmodule

### hw/rtl/mmo_alu.sv
`timescale 1ns / 1ps
module mmo_alu #(
   parameter int WINDOW_LENGTH = mmo_pkg::DEFAULT_WINDOW_LENGTH
) (
   input  logic [mmo_pkg::ALU_OP_W-1:0]                                 op,
   input  logic signed [mmo_pkg::SAMPLE_W-1:0]                          tap,
   input  logic signed [mmo_pkg::SAMPLE_W-1:0]                          cand,
   input  logic signed [mmo_pkg::SAMPLE_W-1:0]                          samp,
   input  logic signed [mmo_pkg::SAMPLE_W-1:0]                          med,
   input  logic signed [mmo_pkg::SAMPLE_W+$clog2(WINDOW_LENGTH)-1:0]    acc,
   input  logic [mmo_pkg::SAMPLE_W+$clog2(WINDOW_LENGTH)-1:0]           quo,
   output logic signed [mmo_pkg::SAMPLE_W+$clog2(WINDOW_LENGTH):0]      result
);
   import mmo_pkg::*;

   localparam int ACC_W = SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int AW = ACC_W + 1;

   logic signed [AW-1:0] opa, opb;
   logic sub;

   always_comb begin
      opa = '0;
      opb = '0;
      sub = 1'b1;
      unique case (op)
         ALU_RANK: begin
            opa = AW'(tap);
            opb = AW'(cand);
         end
         ALU_ACC: begin
            opa = AW'(acc);
            opb = AW'(tap);
            sub = 1'b0;
         end
         ALU_DEV: begin
            opa = AW'(samp);
            opb = AW'(med);
         end
         ALU_ABS: begin
            opb = AW'(acc);
         end
         ALU_NEG: begin
            opb = $signed({1'b0, quo});
         end
         default: begin
            sub = 1'b0;
         end
      endcase
   end

   // one adder for every operation
   assign result = opa + (sub ? ~opb : opb) + AW'(sub);

endmodule

### sim/median_mean_outlier_speed_filter_tb.sv
`timescale 1ns / 1ps
module median_mean_outlier_speed_filter_tb;
   import mmo_pkg::*;

   localparam int WIN = DEFAULT_WINDOW_LENGTH;
   localparam int SPEED_MAX = (1 << (SAMPLE_W - 1)) - 1;
   localparam int SPEED_MIN = -(1 << (SAMPLE_W - 1));
   localparam int SETTLE_CYCLES = 250;
   localparam int LONG_HOLD = 600;
   localparam int QUIET_LIMIT = 5000;
   localparam int REPORT_MAX = 40;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] speed;
      logic startup;
      logic fixed;
   } speed_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_wen = 1'b0;
   logic [REG_IDX_W-1:0] csr_index = REG_CLAMP;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   // predictor copy of the block
   logic [LIMIT_W-1:0] cfg_clamp;
   logic [LIMIT_W-1:0] cfg_thresh;
   logic [LIMIT_W-1:0] cfg_large;
   logic [BAND_W-1:0] cfg_band;
   logic signed [SAMPLE_W-1:0] win_buf [2][WIN];
   int win_pos [2];
   int win_fill [2];

   logic [SAMPLE_W-1:0] raw_speeds [$];
   speed_result_type expected_speeds [$];

   bit idle_on = 1'b0;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;
   int stall_left = 0;
   int req_gap = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int quiet_cycles = 0;
   int bad_count = 0;
   int results_seen = 0;
   int startups_seen = 0;
   int fixes_seen = 0;

   median_mean_outlier_speed_filter dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit window_push(int s, int x, output int med, output bit startup);
      int sorted [WIN];
      int t;
      int zeros;
      win_buf[s][win_pos[s]] = SAMPLE_W'(x);
      win_pos[s] = (win_pos[s] + 1) % WIN;
      if (win_fill[s] < WIN) win_fill[s]++;
      med = 0;
      startup = 1'b0;
      if (win_fill[s] < WIN) return 1'b0;
      for (int i = 0; i < WIN; i++) sorted[i] = int'(win_buf[s][i]);
      for (int i = 0; i < WIN - 1; i++) begin
         for (int j = 0; j < WIN - 1 - i; j++) begin
            if (sorted[j] > sorted[j+1]) begin
               t = sorted[j];
               sorted[j] = sorted[j+1];
               sorted[j+1] = t;
            end
         end
      end
      med = sorted[WIN/2];
      zeros = 0;
      for (int i = 0; i < WIN; i++) begin
         if (magnitude(sorted[i]) < int'(cfg_band)) zeros++;
      end
      startup = zeros > WIN - 2;
      return 1'b1;
   endfunction

   function automatic speed_result_type filter_speed(logic signed [SAMPLE_W-1:0] raw);
      speed_result_type r;
      int x;
      int y;
      int z;
      int med;
      int lim;
      int k;
      int sum;
      bit start;
      bit st2;
      bit fixed;
      x = int'(raw);
      lim = int'(cfg_clamp);
      if (x > lim) x = lim;
      else if (x < -lim) x = -lim;
      fixed = 1'b0;
      y = x;
      if (window_push(0, x, med, start)) begin
         if (!start) begin
            k = (win_pos[0] + WIN - 1) % WIN;
            if (x > int'(cfg_large)) begin
               win_buf[0][k] = '0;
               fixed = 1'b1;
            end else if (magnitude(x - med) > int'(cfg_thresh)) begin
               win_buf[0][k] = SAMPLE_W'(med);
               fixed = 1'b1;
            end
         end
         sum = 0;
         for (int i = 0; i < WIN; i++) sum += int'(win_buf[0][i]);
         y = sum / WIN;
      end
      z = y;
      if (window_push(1, y, med, st2) && !st2 && magnitude(y - med) > int'(cfg_thresh)) begin
         z = med;
         fixed = 1'b1;
      end
      r.speed = SAMPLE_W'(z);
      r.startup = start;
      r.fixed = fixed;
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (raw_speeds.size() != 0) begin
            req_tdata <= DATA_W'(raw_speeds.pop_front());
            req_tvalid <= 1'b1;
            req_gap <= idle_on ? int'($urandom_range(0, 4)) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready with per-response stalls and long hold-offs
   always @(negedge clock) begin : response_ready
      int pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (rsp_fire) begin
         pause = idle_on ? int'($urandom_range(0, 4)) : 0;
         stall_left <= (pause > 0) ? pause - 1 : 0;
         rsp_tready <= (pause == 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin : monitor
      speed_result_type want;
      logic signed [SAMPLE_W-1:0] got_speed;
      bit wrong;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         quiet_cycles <= 0;
         cfg_clamp <= CLAMP_RESET;
         cfg_thresh <= THRESHOLD_RESET;
         cfg_large <= LARGE_RESET;
         cfg_band <= BAND_RESET;
         for (int s = 0; s < 2; s++) begin
            win_pos[s] = 0;
            win_fill[s] = 0;
            for (int i = 0; i < WIN; i++) win_buf[s][i] = '0;
         end
      end else begin
         req_fire <= req_tvalid && req_tready;
         rsp_fire <= rsp_tvalid && rsp_tready;
         if (csr_wen) begin
            case (csr_index)
               REG_CLAMP: cfg_clamp <= csr_wdata;
               REG_THRESHOLD: cfg_thresh <= csr_wdata;
               REG_LARGE: cfg_large <= csr_wdata;
               REG_BAND: cfg_band <= csr_wdata[BAND_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_speeds.push_back(filter_speed(req_tdata[SAMPLE_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got_speed = rsp_tdata[SAMPLE_W-1:0];
            results_seen++;
            if (rsp_tuser[0]) startups_seen++;
            if (rsp_tuser[1]) fixes_seen++;
            if (expected_speeds.size() == 0) begin
               bad_count++;
               if (bad_count <= REPORT_MAX)
                  $display("%0t: response with none expected, speed %0d", $time, got_speed);
            end else begin
               want = expected_speeds.pop_front();
               wrong = 1'b0;
               if (got_speed !== want.speed) begin
                  wrong = 1'b1;
                  if (bad_count < REPORT_MAX)
                     $display("%0t: filtered_speed expected %0d actual %0d",
                              $time, want.speed, got_speed);
               end
               if (rsp_tuser[0] !== want.startup) begin
                  wrong = 1'b1;
                  if (bad_count < REPORT_MAX)
                     $display("%0t: startup_seen expected %0b actual %0b",
                              $time, want.startup, rsp_tuser[0]);
               end
               if (rsp_tuser[1] !== want.fixed) begin
                  wrong = 1'b1;
                  if (bad_count < REPORT_MAX)
                     $display("%0t: outlier_fixed expected %0b actual %0b",
                              $time, want.fixed, rsp_tuser[1]);
               end
               if (wrong) bad_count++;
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[LIMIT_W-1:0];
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_filter(int unsigned clamp, int unsigned thresh, int unsigned large_limit,
                             int unsigned band);
      write_reg(REG_CLAMP, clamp);
      write_reg(REG_THRESHOLD, thresh);
      write_reg(REG_LARGE, large_limit);
      write_reg(REG_BAND, band);
   endtask

   task automatic wait_drained();
      while (raw_speeds.size() != 0 || req_tvalid || expected_speeds.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_speed(int v);
      if (v > SPEED_MAX) v = SPEED_MAX;
      if (v < SPEED_MIN) v = SPEED_MIN;
      raw_speeds.push_back(SAMPLE_W'(v));
   endtask

   task automatic run_phase(int count, bit idling, bit with_hold);
      int level;
      int burst;
      int mode;
      int v;
      idle_on = idling;
      level = int'($urandom_range(0, 60000)) - 30000;
      burst = 0;
      mode = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            mode = $urandom_range(0, 9);
         end
         burst--;
         case (mode)
            0, 1, 2, 3, 4: begin
               level += int'($urandom_range(0, 600)) - 300;
               if (level > SPEED_MAX) level = SPEED_MAX;
               if (level < SPEED_MIN) level = SPEED_MIN;
               v = level;
            end
            5, 6: v = int'($urandom_range(0, 40)) - 20;
            7: v = level + int'($urandom_range(0, 20000)) - 10000;
            8: v = int'($urandom_range(0, 262143)) + SPEED_MIN;
            default: v = level + int'($urandom_range(0, 200000)) - 100000;
         endcase
         queue_speed(v);
      end
      if (with_hold) holds_asked++;
      wait_drained();
   endtask

   initial begin : stimulus
      int unsigned band;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // start-up, band edges and clamping at the reset settings
      idle_on = 1'b1;
      repeat (WIN) queue_speed(0);
      queue_speed(SPEED_MAX);
      queue_speed(SPEED_MIN);
      queue_speed(15);
      queue_speed(-15);
      queue_speed(16);
      queue_speed(-16);
      queue_speed(1000);
      queue_speed(1700);
      queue_speed(3000);
      wait_drained();

      // large positive samples, no zero band, zero threshold
      set_filter(LIMIT_MAX, 0, 1000, 0);
      queue_speed(SPEED_MAX);
      queue_speed(SPEED_MIN);
      queue_speed(1001);
      queue_speed(1000);
      queue_speed(-5000);
      queue_speed(SPEED_MAX);
      wait_drained();

      set_filter(CLAMP_RESET, THRESHOLD_RESET, LARGE_RESET, BAND_RESET);
      run_phase(200, 1'b1, 1'b1);
      set_filter(LIMIT_MAX, 0, 0, 0);
      run_phase(200, 1'b0, 1'b0);
      set_filter(0, LIMIT_MAX, LIMIT_MAX, BAND_MAX);
      run_phase(40, 1'b1, 1'b0);
      set_filter(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, BAND_MAX);
      run_phase(180, 1'b1, 1'b0);
      for (int p = 0; p < 6; p++) begin
         band = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LIMIT_MAX)
                                            : $urandom_range(0, 64);
         set_filter($urandom_range(20000, LIMIT_MAX), $urandom_range(0, 8000),
                    $urandom_range(0, LIMIT_MAX), band);
         run_phase(200, (p % 3) != 2, p == 2);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("filtered %0d speed samples over twelve register settings", results_seen);
      $display("start-up windows %0d, outlier repairs %0d, long output stalls %0d",
               startups_seen, fixes_seen, holds_done);
      if (bad_count == 0 && expected_speeds.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### median_mean_outlier_speed_filter.f
hw/rtl/mmo_pkg.sv
hw/rtl/mmo_window.sv
hw/rtl/mmo_alu.sv
hw/rtl/median_mean_outlier_speed_filter.sv
sim/median_mean_outlier_speed_filter_tb.sv
